FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the hash table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that the consequent holds in the cycle of the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
// Checks a condition at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("assertion failed");
`endif

FILE: rtl/tlph_pkg.sv
// Package with the types and constants of the tagged linear probe hash table.
`timescale 1ns / 1ps
`default_nettype none
package tlph_pkg;
	localparam int SLOTS_DEF = 1024;
	localparam int KEY_BITS_DEF = 64;
	localparam int CFG_W = 11;
	localparam int SLOT_OUT_W = 10;
	localparam int COUNT_OUT_W = 11;
	localparam int TAG_W = 7;
	localparam int HASH_W = 64;
	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 11'd1024;
	localparam logic [7:0] CTRL_EMPTY = 8'h80;
	localparam logic [7:0] CTRL_DELETED = 8'hfe;
	localparam logic REG_SLOTS_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_FIRST,
		ST_PROBE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       ctrl_we;
		logic       key_we;
		logic [7:0] ctrl_wdata;
	} mem_wr_t;
endpackage
`default_nettype wire

FILE: rtl/tlph_rem.sv
// Iterative remainder unit: start position as the hash index modulo the slot count.
`timescale 1ns / 1ps
`default_nettype none
module tlph_rem (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [56:0]              value,
	input  wire logic [tlph_pkg::CFG_W-1:0] divisor,
	output logic                          done,
	output logic [tlph_pkg::CFG_W-1:0]    rem
);
	import tlph_pkg::*;

	localparam int DIG = 4;
	localparam int STEPS = 15;
	localparam int PAD_W = DIG * STEPS;

	logic [PAD_W-1:0] shift_q;
	logic [CFG_W-1:0] div_q;
	logic [CFG_W-1:0] rem_q;
	logic [3:0] cnt_q;
	logic busy_q;
	logic [CFG_W-1:0] rem_next;

	// Four restoring steps per cycle; the partial remainder stays below the divisor.
	always_comb begin
		logic [CFG_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIG; i++) begin
			r = {r[CFG_W-1:0], shift_q[PAD_W-1-i]};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
			end
		end
		rem_next = r[CFG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= {{(PAD_W-57){1'b0}}, value};
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << DIG;
			rem_q <= rem_next;
		end
	end

	assign rem = rem_q;
endmodule
`default_nettype wire

FILE: rtl/tlph_store.sv
// Control byte and key memories with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tlph_store #(
	parameter int SLOTS = tlph_pkg::SLOTS_DEF,
	parameter int KEY_BITS = tlph_pkg::KEY_BITS_DEF,
	localparam int IDX_W = $clog2(SLOTS)
) (
	input  wire logic                    clk,
	input  wire logic [IDX_W-1:0]        rd_addr,
	output logic [7:0]                   ctrl_rd,
	output logic [KEY_BITS-1:0]          key_rd,
	input  wire tlph_pkg::mem_wr_t       wr,
	input  wire logic [IDX_W-1:0]        wr_addr,
	input  wire logic [KEY_BITS-1:0]     key_wdata
);
	import tlph_pkg::*;

	logic [7:0] ctrl_mem [SLOTS];
	logic [KEY_BITS-1:0] key_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr.ctrl_we) begin
			ctrl_mem[wr_addr] <= wr.ctrl_wdata;
		end
		ctrl_rd <= ctrl_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr_addr] <= key_wdata;
		end
		key_rd <= key_mem[rd_addr];
	end
endmodule
`default_nettype wire

FILE: rtl/tagged_linear_probe_hash_table.sv
// Top level of the tagged linear probe hash table: control, probe sequencer and ports.
// The start position comes from the remainder unit; a request then makes P probes (1 to slots
// in use), reading one slot a cycle, and ends in ST_DONE; MODE_NONE goes straight to ST_DONE.
// One request at a time; the next is taken once the result is in the output register.
// After reset a clearing pass writes every control byte empty; no request
// is taken during it. Configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tagged_linear_probe_hash_table #(
	parameter int SLOTS = tlph_pkg::SLOTS_DEF,
	parameter int KEY_BITS = tlph_pkg::KEY_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [63:0] hash,
	input  wire logic [63:0] key,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [9:0]       slot,
	output logic             already_present,
	output logic [10:0]      live_count
);
	import tlph_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	state_t state_q, state_d;
	logic [CFG_W-1:0] slots_q;
	logic [CFG_W-1:0] n_eff;
	logic [CFG_W-1:0] n_q;
	mode_t mode_q;
	logic [TAG_W-1:0] tag_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0] pos_q, pos_next, free_q, free_now, clr_q;
	logic [CFG_W-1:0] cnt_q;
	logic have_free_q;
	logic [CNT_W-1:0] count_q;
	logic res_ok_q, res_pres_q;
	logic [IDX_W-1:0] res_slot_q;
	logic out_valid_q;

	logic in_acc, rem_start, rem_done;
	logic [CFG_W-1:0] rem;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	mem_wr_t wr;
	logic [7:0] ctrl_rd;
	logic [KEY_BITS-1:0] key_rd;

	logic is_empty, is_del, hit, last, free_valid, stop, is_ins;

	// Configuration port.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_IN_USE_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_SLOTS_IN_USE) begin
			slots_q <= pwdata[CFG_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? {{(32-CFG_W){1'b0}}, slots_q} : 32'd0;

	always_comb begin
		if (slots_q == '0) begin
			n_eff = CFG_W'(1);
		end else if ({{(32-CFG_W){1'b0}}, slots_q} > 32'(SLOTS)) begin
			n_eff = CFG_W'(SLOTS);
		end else begin
			n_eff = slots_q;
		end
	end

	assign in_acc = in_valid && !in_stall;

	tlph_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.value   (hash[63:7]),
		.divisor (n_eff),
		.done    (rem_done),
		.rem     (rem)
	);

	tlph_store #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_store (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.ctrl_rd   (ctrl_rd),
		.key_rd    (key_rd),
		.wr        (wr),
		.wr_addr   (wr_addr),
		.key_wdata (key_q)
	);

	// Probe decision on the slot read in the previous cycle.
	assign is_ins = (mode_q == MODE_INSERT);
	assign is_empty = (ctrl_rd == CTRL_EMPTY);
	assign is_del = (ctrl_rd == CTRL_DELETED);
	assign hit = (ctrl_rd == {1'b0, tag_q}) && (key_rd == key_q);
	assign last = ({{(32-CFG_W){1'b0}}, cnt_q} == 32'(n_q) - 32'd1);
	assign stop = hit || is_empty || last;
	assign free_now = have_free_q ? free_q : pos_q;
	assign free_valid = is_ins && (have_free_q || is_empty || is_del);
	assign pos_next = (32'(pos_q) + 32'd1 >= 32'(n_q)) ? '0 : pos_q + IDX_W'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_W'(SLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) state_d = (mode_t'(mode) == MODE_NONE) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (rem_done) state_d = ST_FIRST;
			end
			ST_FIRST: state_d = ST_PROBE;
			ST_PROBE: begin
				if (stop) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall = 1'b1;
		rem_start = 1'b0;
		rd_addr = pos_q;
		wr = '0;
		wr_addr = pos_q;
		case (state_q)
			ST_CLEAR: begin
				wr.ctrl_we = 1'b1;
				wr.ctrl_wdata = CTRL_EMPTY;
				wr_addr = clr_q;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				rem_start = in_valid && mode_t'(mode) != MODE_NONE;
			end
			ST_PROBE: begin
				rd_addr = pos_next;
				if (stop) begin
					if (hit) begin
						if (mode_q == MODE_DELETE) begin
							wr.ctrl_we = 1'b1;
							wr.ctrl_wdata = CTRL_DELETED;
						end
					end else if (free_valid) begin
						wr.ctrl_we = 1'b1;
						wr.key_we = 1'b1;
						wr.ctrl_wdata = {1'b0, tag_q};
						wr_addr = free_now;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
			if (state_q == ST_PROBE && stop) begin
				if (hit) begin
					if (mode_q == MODE_DELETE && count_q != '0) count_q <= count_q - CNT_W'(1);
				end else if (free_valid) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current request and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q <= mode_t'(mode);
				tag_q <= hash[TAG_W-1:0];
				key_q <= key[KEY_BITS-1:0];
				n_q <= n_eff;
				res_ok_q <= 1'b0;
				res_pres_q <= 1'b0;
				res_slot_q <= '0;
			end
			ST_DIV: begin
				pos_q <= IDX_W'(rem);
				cnt_q <= '0;
				have_free_q <= 1'b0;
			end
			ST_PROBE: begin
				if (stop) begin
					if (hit) begin
						res_ok_q <= 1'b1;
						res_slot_q <= pos_q;
						res_pres_q <= is_ins;
					end else if (free_valid) begin
						res_ok_q <= 1'b1;
						res_slot_q <= free_now;
					end
				end else begin
					pos_q <= pos_next;
					cnt_q <= cnt_q + CFG_W'(1);
					if (is_ins && is_del && !have_free_q) begin
						have_free_q <= 1'b1;
						free_q <= pos_q;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ok <= res_ok_q;
					slot <= SLOT_OUT_W'(res_slot_q);
					already_present <= res_pres_q;
					live_count <= COUNT_OUT_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, 32'(count_q) <= 32'(SLOTS))
	`ASSERT_IMPLY(a_key_write_in_probe, clk, arst_n, wr.key_we, state_q == ST_PROBE && is_ins)
	`ASSERT_IMPLY(a_fail_slot_zero, clk, arst_n, out_valid_q && !ok, slot == '0 && !already_present)
	`ASSERT_NEXT(a_div_leads_probe, clk, arst_n, state_q == ST_DIV && rem_done, state_q == ST_FIRST)
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the tagged linear probe hash table.
`timescale 1ns / 1ps
module tb_top;
	import tlph_pkg::*;

	localparam int NSLOT = 1024;
	localparam int WATCHDOG_LIMIT = 60000;

	typedef struct {
		logic       ok;
		logic [9:0] slot;
		logic       present;
		logic [10:0] count;
	} lookup_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_INSERT;
	logic [63:0] hash = '0, key = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic ok, already_present;
	logic [9:0] slot;
	logic [10:0] live_count;

	// Predictor state.
	logic [7:0] ctrl_mirror [NSLOT];
	logic [63:0] key_mirror [NSLOT];
	logic [10:0] count_mirror;
	logic [10:0] slots_cfg;
	lookup_result_t pending_results[$];
	// Keys of all insert requests sent, used to pick find and delete requests.
	logic [63:0] known_hash[$];
	logic [63:0] known_key[$];

	int errors = 0;
	int idle_cycles = 0;
	bit sender_gaps = 1'b1;
	bit receiver_gaps = 1'b1;
	bit long_hold = 1'b0;

	tagged_linear_probe_hash_table dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic lookup_result_t predict_lookup(logic [1:0] op, logic [63:0] h,
			logic [63:0] k);
		lookup_result_t r;
		int n, pos, free_pos;
		bit have_free;
		logic [6:0] tag;
		r = '{1'b0, 10'd0, 1'b0, 11'd0};
		n = slots_cfg;
		tag = h[6:0];
		have_free = 1'b0;
		free_pos = 0;
		if (n == 0) n = 1;
		if (n > NSLOT) n = NSLOT;
		pos = int'((h >> 7) % 64'(n));
		if (op != MODE_NONE) begin
			for (int i = 0; i < n; i++) begin
				if (ctrl_mirror[pos] == CTRL_EMPTY) begin
					if (op == MODE_INSERT && !have_free) begin
						have_free = 1'b1;
						free_pos = pos;
					end
					break;
				end
				if (ctrl_mirror[pos] == CTRL_DELETED) begin
					if (op == MODE_INSERT && !have_free) begin
						have_free = 1'b1;
						free_pos = pos;
					end
				end else if (ctrl_mirror[pos] == {1'b0, tag} && key_mirror[pos] == k) begin
					if (op == MODE_DELETE) begin
						ctrl_mirror[pos] = CTRL_DELETED;
						if (count_mirror > 0) count_mirror--;
					end
					r.ok = 1'b1;
					r.slot = pos[9:0];
					r.present = (op == MODE_INSERT);
					r.count = count_mirror;
					return r;
				end
				pos = (pos + 1 >= n) ? 0 : pos + 1;
			end
			if (op == MODE_INSERT && have_free) begin
				ctrl_mirror[free_pos] = {1'b0, tag};
				key_mirror[free_pos] = k;
				count_mirror++;
				r.ok = 1'b1;
				r.slot = free_pos[9:0];
			end
		end
		r.count = count_mirror;
		return r;
	endfunction

	task automatic apb_write_slots(input logic [10:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_SLOTS_IN_USE);
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		slots_cfg = value;
	endtask

	// Sends one request, predicting its result at the edge where it is taken.
	task automatic send_request(input logic [1:0] op, input logic [63:0] h,
			input logic [63:0] k);
		int gap;
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		hash <= h;
		key <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_lookup(op, h, k));
		if (op == MODE_INSERT) begin
			known_hash.push_back(h);
			known_key.push_back(k);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		// Latency allowance; results are one per request so this is just margin.
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Picks a random request; some inserts start at the last slot in use so that probes wrap.
	task automatic random_request(input int n);
		logic [63:0] h, k;
		logic [1:0] op;
		int idx, sel;
		sel = $urandom_range(0, 99);
		if (sel < 45 || known_hash.size() == 0) begin
			op = MODE_INSERT;
			h = rand64();
			k = rand64();
			// Collide often so that probe chains grow.
			if ($urandom_range(0, 1)) h[16:7] = 10'($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0) h[63:7] = 57'(n - 1);
			if ($urandom_range(0, 3) == 0 && known_hash.size() != 0) begin
				idx = $urandom_range(0, known_hash.size() - 1);
				h = known_hash[idx];
				k = known_key[idx];
			end
		end else if (sel < 95) begin
			idx = $urandom_range(0, known_hash.size() - 1);
			op = (sel < 70) ? MODE_FIND : MODE_DELETE;
			h = known_hash[idx];
			k = known_key[idx];
			if ($urandom_range(0, 9) == 0) k[$urandom_range(0, 63)] ^= 1'b1;
		end else begin
			op = (sel < 98) ? 2'($urandom_range(1, 2)) : MODE_NONE;
			h = rand64();
			k = rand64();
		end
		send_request(op, h, k);
	endtask

	task automatic test_directed();
		send_request(MODE_FIND, 64'd0, 64'd0);
		send_request(MODE_INSERT, 64'd0, 64'd0);
		send_request(MODE_INSERT, 64'd0, 64'd0);
		send_request(MODE_INSERT, '1, '1);
		send_request(MODE_INSERT, 64'h7f, 64'h1);
		send_request(MODE_FIND, '1, '1);
		send_request(MODE_NONE, '1, '1);
		send_request(MODE_DELETE, 64'd0, 64'd0);
		send_request(MODE_DELETE, 64'd0, 64'd0);
		send_request(MODE_FIND, 64'h7f, 64'h1);
		send_request(MODE_INSERT, 64'h80, 64'h5555_aaaa_5555_aaaa);
		send_request(MODE_FIND, 64'h80, 64'haaaa_5555_aaaa_5555);
		wait_drained();
	endtask

	// Tiny tables and a too-large slot count: full-table inserts, tombstone reuse and wrapping.
	task automatic test_small_tables();
		apb_write_slots(11'd0);
		send_request(MODE_INSERT, 64'h1234, 64'd7);
		send_request(MODE_INSERT, 64'h1235, 64'd8);
		send_request(MODE_DELETE, 64'h1234, 64'd7);
		send_request(MODE_INSERT, 64'h1235, 64'd8);
		wait_drained();
		apb_write_slots(11'd4);
		for (int i = 0; i < 7; i++) send_request(MODE_INSERT, rand64(), rand64());
		send_request(MODE_DELETE, known_hash[known_hash.size() - 6],
			known_key[known_key.size() - 6]);
		for (int i = 0; i < 3; i++) send_request(MODE_INSERT, rand64(), rand64());
		wait_drained();
		apb_write_slots(11'd2047);
		for (int i = 0; i < 40; i++) random_request(NSLOT);
		wait_drained();
		apb_write_slots(11'd1);
		for (int i = 0; i < 20; i++) random_request(1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		apb_write_slots(11'd16);
		long_hold = 1'b1;
		for (int i = 0; i < 12; i++) random_request(16);
		long_hold = 1'b0;
		wait_drained();
		// Sender pauses until everything has come back.
		for (int i = 0; i < 10; i++) random_request(16);
		wait_drained();
	endtask

	task automatic test_random();
		int sizes[4] = '{1024, 37, 8, 300};
		foreach (sizes[s]) begin
			apb_write_slots(11'(sizes[s]));
			if (s == 3) begin
				sender_gaps = 1'b0;
				receiver_gaps = 1'b0;
			end
			for (int i = 0; i < 90; i++) random_request(sizes[s]);
			wait_drained();
		end
	endtask

	// Receiver stall: random bursts, plus one long hold that backs up the sender through in_stall.
	initial begin
		int len;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				len = 0;
				while (len < 400) begin
					@(negedge clk);
					len++;
				end
				out_stall <= 1'b0;
				wait (!long_hold);
			end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		lookup_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result ok=%0b slot=%0d", $time, ok, slot);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (ok !== e.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, e.ok, ok);
					errors++;
				end
				if (slot !== e.slot) begin
					$display("%0t: slot expected %0d actual %0d", $time, e.slot, slot);
					errors++;
				end
				if (already_present !== e.present) begin
					$display("%0t: already_present expected %0b actual %0b", $time,
						e.present, already_present);
					errors++;
				end
				if (live_count !== e.count) begin
					$display("%0t: live_count expected %0d actual %0d", $time,
						e.count, live_count);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on the request, result or configuration port.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			ctrl_mirror[i] = CTRL_EMPTY;
			key_mirror[i] = '0;
		end
		count_mirror = '0;
		slots_cfg = SLOTS_IN_USE_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_small_tables();
		test_backpressure();
		test_random();
		wait_drained();
		if (errors == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
